// ----- hw/rtl/lmfr_pkg.sv -----
// Shared types, codes and helpers for the LED matrix framebuffer remap block.
`timescale 1ns / 1ps
`default_nettype none
package lmfr_pkg;

    localparam int unsigned MAP_W     = 24;
    localparam int unsigned ORIENT_W  = 9;
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned BRIGHT_W  = 4;
    localparam int unsigned FRAME_BITS = 128;
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned M_DATA_W  = 32;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 32;

    localparam logic [MAP_W-1:0]    MAP_RESET     = 24'hFAC688;
    localparam logic [BRIGHT_W-1:0] CEILING_RESET = 4'd15;

    // Operation codes carried on the input tuser
    typedef enum logic [2:0] {
        FN_SET_PIX   = 3'd0,
        FN_CLR_PIX   = 3'd1,
        FN_RD_PIX    = 3'd2,
        FN_CLR_ALL   = 3'd3,
        FN_FILL_ALL  = 3'd4,
        FN_UPDATE    = 3'd5,
        FN_SET_BRIGHT = 3'd6,
        FN_RD_BRIGHT = 3'd7
    } func_t;

    // Result kinds carried on the output tuser
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_BRIGHT    = 2'd1,
        KIND_INTENSITY = 2'd2,
        KIND_ROW       = 2'd3
    } kind_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_ORIENT   = 3'd0,
        CFG_SEG_DEV0 = 3'd1,
        CFG_SEG_DEV1 = 3'd2,
        CFG_DIG_DEV0 = 3'd3,
        CFG_DIG_DEV1 = 3'd4,
        CFG_CEILING  = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Framebuffer commands from the sequencer
    typedef struct packed {
        logic       set_pix;
        logic       clr_pix;
        logic       clr_all;
        logic       fill_all;
        logic       walk;
        logic [2:0] row;
        logic [3:0] col;
    } frame_ctl_t;

    // Pick 3-bit entry idx out of a packed eight-entry map
    function automatic logic [2:0] map_entry(input logic [MAP_W-1:0] map,
                                             input logic [2:0] idx);
        logic [4:0] sh;
        sh = 5'(idx) * 5'd3;
        return map[sh +: 3];
    endfunction

    // Pack result fields into the output word, lowest field first
    function automatic logic [M_DATA_W-1:0] pack_out(input logic [3:0] addr,
                                                    input logic [7:0] b0,
                                                    input logic [7:0] b1,
                                                    input logic       pix,
                                                    input logic [3:0] inten);
        return {7'd0, inten, pix, b1, b0, addr};
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lmfr_frame.sv -----
// Framebuffer held as a 128-bit ring that rotates one pixel per cycle during a walk.
`timescale 1ns / 1ps
`default_nettype none
module lmfr_frame (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lmfr_pkg::frame_ctl_t ctl,
    output logic                     walk_bit,
    output logic                     rd_bit
);
    import lmfr_pkg::*;

    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [6:0]            idx;

    // Bit index is row * 16 + column
    assign idx      = {ctl.row, ctl.col};
    assign rd_bit   = frame_reg[idx];
    assign walk_bit = frame_reg[0];

    // Apply bulk ops, rotate during a walk, else single pixel writes
    always_comb begin
        frame_next = frame_reg;
        if (ctl.clr_all) begin
            frame_next = '0;
        end else if (ctl.fill_all) begin
            frame_next = '1;
        end else if (ctl.walk) begin
            frame_next = {frame_reg[0], frame_reg[FRAME_BITS-1:1]};
        end else if (ctl.set_pix) begin
            frame_next[idx] = 1'b1;
        end else if (ctl.clr_pix) begin
            frame_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
        end else begin
            frame_reg <= frame_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lmfr_remap.sv -----
// Per-pixel rotation, flip and table mapping into the two chips' row bytes.
`timescale 1ns / 1ps
`default_nettype none
module lmfr_remap (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          pix,
    input  wire logic [3:0]                    x,
    input  wire logic [2:0]                    y,
    input  wire logic [lmfr_pkg::ORIENT_W-1:0] orient,
    input  wire logic [lmfr_pkg::MAP_W-1:0]    seg_map0,
    input  wire logic [lmfr_pkg::MAP_W-1:0]    seg_map1,
    input  wire logic [lmfr_pkg::MAP_W-1:0]    dig_map0,
    input  wire logic [lmfr_pkg::MAP_W-1:0]    dig_map1,
    input  wire logic                          shift,
    output logic [7:0]                         byte0,
    output logic [7:0]                         byte1
);
    import lmfr_pkg::*;

    logic [7:0] acc0_reg [8];
    logic [7:0] acc0_next [8];
    logic [7:0] acc1_reg [8];
    logic [7:0] acc1_next [8];

    logic       mat;
    logic       dev;
    logic [3:0] cfg;
    logic [2:0] lx;
    logic [2:0] px;
    logic [2:0] py;
    logic [2:0] dig;
    logic [2:0] seg;

    // Select the matrix orientation and its driver chip
    assign mat = x[3];
    assign lx  = x[2:0];
    assign cfg = mat ? orient[8:5] : orient[4:1];
    assign dev = orient[0] ^ mat;

    // Rotate, then flip; 7 - v is the bitwise inverse on three bits
    always_comb begin
        case (cfg[1:0])
            2'd1:    begin px = ~y;  py = lx;  end
            2'd2:    begin px = ~lx; py = ~y;  end
            2'd3:    begin px = y;   py = ~lx; end
            default: begin px = lx;  py = y;   end
        endcase
        if (cfg[2]) px = ~px;
        if (cfg[3]) py = ~py;
    end

    assign dig = map_entry(dev ? dig_map1 : dig_map0, py);
    assign seg = map_entry(dev ? seg_map1 : seg_map0, px);

    assign byte0 = acc0_reg[0];
    assign byte1 = acc1_reg[0];

    // Shift rows out towards index 0, or set the mapped bit of a lit pixel
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            acc0_next[i] = acc0_reg[i];
            acc1_next[i] = acc1_reg[i];
        end
        if (shift) begin
            for (int i = 0; i < 7; i++) begin
                acc0_next[i] = acc0_reg[i+1];
                acc1_next[i] = acc1_reg[i+1];
            end
            acc0_next[7] = '0;
            acc1_next[7] = '0;
        end else if (en && pix) begin
            if (dev) begin
                acc1_next[dig][seg] = 1'b1;
            end else begin
                acc0_next[dig][seg] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                acc0_reg[i] <= '0;
                acc1_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 8; i++) begin
                acc0_reg[i] <= acc0_next[i];
                acc1_reg[i] <= acc1_next[i];
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/led_matrix_framebuffer_remap_core.sv -----
// Pixel and brightness results appear in the cycle after the word is accepted.
// Update: walk the framebuffer ring one pixel per cycle, then eight row writes at one
// per cycle as the output is taken; no word is taken until the last row is out.
// All other operations are handled in the idle state as the word is accepted.
// Reset (synchronous, aresetn low) blanks the frame, loads the default intensity and
// restores every configuration register; the block is ready as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module led_matrix_framebuffer_remap_core #(
    parameter logic [3:0] DEFAULT_INTENSITY = 4'd8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lmfr_pkg::S_DATA_W-1:0] s_tdata,  // col[3:0], row[6:4], level[14:7]
    input  wire logic [2:0]                    s_tuser,  // func[2:0]
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // reg_addr[3:0], dev0_byte[11:4], dev1_byte[19:12], pixel_on[20], intensity[24:21]
    output logic [lmfr_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [1:0]                         m_tuser,  // kind[1:0]
    output logic                               m_tlast,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lmfr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lmfr_pkg::APB_DW-1:0]   pwdata,
    output logic [lmfr_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import lmfr_pkg::*;

    // Configuration registers
    logic [ORIENT_W-1:0] orient_reg;
    logic [MAP_W-1:0]    seg0_reg;
    logic [MAP_W-1:0]    seg1_reg;
    logic [MAP_W-1:0]    dig0_reg;
    logic [MAP_W-1:0]    dig1_reg;
    logic [BRIGHT_W-1:0] ceil_reg;
    logic                cfg_wr;
    cfg_idx_t            cfg_idx;

    // Sequencer and state
    state_t              state_reg, state_next;
    logic [6:0]          walk_cnt_reg, walk_cnt_next;
    logic [2:0]          emit_cnt_reg, emit_cnt_next;
    logic [BRIGHT_W-1:0] bright_reg, bright_next;

    // Output register
    logic                m_valid_reg, m_valid_next;
    kind_t               m_kind_reg, m_kind_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic                out_free;
    logic                in_acc;
    func_t               in_func;
    logic [3:0]          in_col;
    logic [2:0]          in_row;
    logic [LEVEL_W-1:0]  in_level;
    logic [BRIGHT_W-1:0] clamped;

    frame_ctl_t          fctl;
    logic                walk_bit;
    logic                rd_bit;
    logic                shift;
    logic [7:0]          byte0;
    logic [7:0]          byte1;

    // Configuration write and read
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[4:2]);

    always_comb begin
        unique case (cfg_idx)
            CFG_ORIENT:   prdata = APB_DW'(orient_reg);
            CFG_SEG_DEV0: prdata = APB_DW'(seg0_reg);
            CFG_SEG_DEV1: prdata = APB_DW'(seg1_reg);
            CFG_DIG_DEV0: prdata = APB_DW'(dig0_reg);
            CFG_DIG_DEV1: prdata = APB_DW'(dig1_reg);
            CFG_CEILING:  prdata = APB_DW'(ceil_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg <= '0;
            seg0_reg   <= MAP_RESET;
            seg1_reg   <= MAP_RESET;
            dig0_reg   <= MAP_RESET;
            dig1_reg   <= MAP_RESET;
            ceil_reg   <= CEILING_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_ORIENT:   orient_reg <= pwdata[ORIENT_W-1:0];
                CFG_SEG_DEV0: seg0_reg   <= pwdata[MAP_W-1:0];
                CFG_SEG_DEV1: seg1_reg   <= pwdata[MAP_W-1:0];
                CFG_DIG_DEV0: dig0_reg   <= pwdata[MAP_W-1:0];
                CFG_DIG_DEV1: dig1_reg   <= pwdata[MAP_W-1:0];
                CFG_CEILING:  ceil_reg   <= pwdata[BRIGHT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Unpack the input word
    assign in_func  = func_t'(s_tuser);
    assign in_col   = s_tdata[3:0];
    assign in_row   = s_tdata[6:4];
    assign in_level = s_tdata[14:7];
    assign clamped  = (in_level > LEVEL_W'(ceil_reg)) ? ceil_reg : in_level[BRIGHT_W-1:0];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Sequence operations, the walk and the row emission
    always_comb begin
        state_next    = state_reg;
        walk_cnt_next = walk_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        bright_next   = bright_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        fctl          = '0;
        fctl.row      = in_row;
        fctl.col      = in_col;
        shift         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_func)
                        FN_SET_PIX:  fctl.set_pix = 1'b1;
                        FN_CLR_PIX:  fctl.clr_pix = 1'b1;
                        FN_CLR_ALL:  fctl.clr_all = 1'b1;
                        FN_FILL_ALL: fctl.fill_all = 1'b1;
                        FN_RD_PIX: begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_PIXEL;
                            m_data_next  = pack_out(4'd0, 8'd0, 8'd0, rd_bit, 4'd0);
                            m_last_next  = 1'b1;
                        end
                        FN_UPDATE: begin
                            state_next    = ST_WALK;
                            walk_cnt_next = '0;
                        end
                        FN_SET_BRIGHT: begin
                            if (clamped != bright_reg) begin
                                bright_next  = clamped;
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_INTENSITY;
                                m_data_next  = pack_out(4'd0, 8'd0, 8'd0, 1'b0, clamped);
                                m_last_next  = 1'b1;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_BRIGHT;
                            m_data_next  = pack_out(4'd0, 8'd0, 8'd0, 1'b0, bright_reg);
                            m_last_next  = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                // rotate the ring; bit 0 is pixel (walk_cnt / 16, walk_cnt % 16)
                fctl.walk     = 1'b1;
                walk_cnt_next = walk_cnt_reg + 7'd1;
                if (walk_cnt_reg == 7'd127) begin
                    state_next    = ST_EMIT;
                    emit_cnt_next = '0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    shift         = 1'b1;
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_ROW;
                    m_data_next   = pack_out(4'(emit_cnt_reg) + 4'd1, byte0, byte1,
                                             1'b0, 4'd0);
                    m_last_next   = (emit_cnt_reg == 3'd7);
                    emit_cnt_next = emit_cnt_reg + 3'd1;
                    if (emit_cnt_reg == 3'd7) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            walk_cnt_reg <= '0;
            emit_cnt_reg <= '0;
            bright_reg   <= DEFAULT_INTENSITY;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            walk_cnt_reg <= walk_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            bright_reg   <= bright_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold the output payload
    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    lmfr_frame u_frame (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (fctl),
        .walk_bit (walk_bit),
        .rd_bit   (rd_bit)
    );

    lmfr_remap u_remap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (fctl.walk),
        .pix      (walk_bit),
        .x        (walk_cnt_reg[3:0]),
        .y        (walk_cnt_reg[6:4]),
        .orient   (orient_reg),
        .seg_map0 (seg0_reg),
        .seg_map1 (seg1_reg),
        .dig_map0 (dig0_reg),
        .dig_map1 (dig1_reg),
        .shift    (shift),
        .byte0    (byte0),
        .byte1    (byte1)
    );

    // An update starts its walk from the first pixel
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && in_func == FN_UPDATE) |=> (state_reg == ST_WALK && walk_cnt_reg == 7'd0))
        else $error("update did not start walk at pixel zero");

    // The walk ends in row emission after the last pixel
    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && walk_cnt_reg == 7'd127) |=> (state_reg == ST_EMIT))
        else $error("walk did not hand over to row emission");

    // The eighth row write closes the item and returns to idle
    a_emit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && emit_cnt_reg == 3'd7)
            |=> (state_reg == ST_IDLE && m_valid_reg && m_last_reg))
        else $error("last row write not marked or sequencer not idle");

    // Row writes always address a digit register
    a_row_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_ROW) |-> (m_data_reg[3:0] != 4'd0))
        else $error("row write with zero register address");

    // No word is taken while a walk or emission is running
    a_busy_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while busy");

endmodule
`default_nettype wire
